[hdl/spjq_pkg.sv]
// types, codes and field widths shared by the sorted priority job queue files
package spjq_pkg;

   localparam int TAG_W  = 32;
   localparam int PRIO_W = 8;
   localparam int ORD_W  = 16;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 4;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

   typedef struct packed {
      logic              req_type;
      logic [TAG_W-1:0]  job_tag;
      logic [PRIO_W-1:0] priority_req;
      logic [ORD_W-1:0]  order_tag;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TAG_W-1:0]  out_job_tag;
      logic [PRIO_W-1:0] out_priority;
      logic [ORD_W-1:0]  out_order_tag;
      logic [OCC_W-1:0]  occupancy;
   } rsp_payload_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [ORD_W-1:0]  order;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISCAN,
      S_ICMP,
      S_RM_RD,
      S_RM_DONE,
      S_RSP
   } state_type;

endpackage

[hdl/sorted_priority_job_queue_unit.sv]
// sorted priority job queue: circular entry memory walked by one key comparator
// insert: one stored entry is read in S_ISCAN, then compared and written in S_ICMP, walking
//    back from the tail until the hole reaches slot 0 or the new entry is no longer ahead
// remove: one memory read of the head entry in S_RM_RD, then S_RM_DONE, then the result in S_RSP
// full insert or empty remove: result valid in the cycle after accept
// one item at a time: req_ready is high only while no item is in work or waiting
// synchronous active-high reset empties the queue; memory contents are not cleared
module sorted_priority_job_queue_unit #(
   parameter int CAPACITY = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  spjq_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output spjq_pkg::rsp_payload_type rsp_payload
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   spjq_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [IW-1:0]             head_ff, head_in;
   logic [IW-1:0]             hole_ff, hole_in;
   spjq_pkg::entry_type       new_ff, new_in;
   spjq_pkg::rsp_payload_type rsp_ff, rsp_in;
   spjq_pkg::entry_type       rd_data_ff;

   spjq_pkg::entry_type       mem [CAPACITY];

   logic                      mem_we;
   logic [IW-1:0]             mem_waddr;
   spjq_pkg::entry_type       mem_wdata;
   logic [IW-1:0]             rd_addr;
   logic                      full;
   logic                      empty;
   logic                      new_first;

   // logical slot to physical address, sum stays below twice the depth
   function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [IW-1:0] slot);
      logic [IW:0] sum;
      sum = {1'b0, head} + {1'b0, slot};
      if (sum >= (IW+1)'(CAPACITY)) begin
         sum = sum - (IW+1)'(CAPACITY);
      end
      return sum[IW-1:0];
   endfunction

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);

   // shared comparator: new entry strictly ahead of the stored one
   assign new_first = (new_ff.prio < rd_data_ff.prio) ||
                      ((new_ff.prio == rd_data_ff.prio) && (new_ff.order < rd_data_ff.order));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spjq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_payload.req_type == spjq_pkg::REQ_INSERT) begin
                  state_in = full ? spjq_pkg::S_RSP : spjq_pkg::S_ISCAN;
               end else begin
                  state_in = empty ? spjq_pkg::S_RSP : spjq_pkg::S_RM_RD;
               end
            end
         end
         spjq_pkg::S_ISCAN: begin
            state_in = (hole_ff == '0) ? spjq_pkg::S_RSP : spjq_pkg::S_ICMP;
         end
         spjq_pkg::S_ICMP: begin
            state_in = new_first ? spjq_pkg::S_ISCAN : spjq_pkg::S_RSP;
         end
         spjq_pkg::S_RM_RD: begin
            state_in = spjq_pkg::S_RM_DONE;
         end
         spjq_pkg::S_RM_DONE: begin
            state_in = spjq_pkg::S_RSP;
         end
         spjq_pkg::S_RSP: begin
            if (rsp_ready) begin
               state_in = spjq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spjq_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      hole_in   = hole_ff;
      new_in    = new_ff;
      rsp_in    = rsp_ff;
      mem_we    = 1'b0;
      mem_waddr = phys(head_ff, hole_ff);
      mem_wdata = new_ff;
      rd_addr   = phys(head_ff, IW'(hole_ff - 1'b1));
      req_ready = (state_ff == spjq_pkg::S_IDLE);
      rsp_valid = (state_ff == spjq_pkg::S_RSP);

      case (state_ff)
         spjq_pkg::S_IDLE: begin
            new_in.tag   = req_payload.job_tag;
            new_in.prio  = req_payload.priority_req;
            new_in.order = req_payload.order_tag;
            hole_in      = IW'(count_ff);
            rsp_in.out_job_tag   = '0;
            rsp_in.out_priority  = '0;
            rsp_in.out_order_tag = '0;
            rsp_in.occupancy     = spjq_pkg::OCC_W'(count_ff);
            if (req_payload.req_type == spjq_pkg::REQ_INSERT) begin
               rsp_in.status = spjq_pkg::STAT_FULL;
            end else begin
               rsp_in.status = spjq_pkg::STAT_EMPTY;
            end
         end
         spjq_pkg::S_ISCAN: begin
            if (hole_ff == '0) begin
               mem_we   = 1'b1;
               count_in = CW'(count_ff + 1'b1);
               rsp_in.status    = spjq_pkg::STAT_INSERTED;
               rsp_in.occupancy = spjq_pkg::OCC_W'(count_in);
            end
         end
         spjq_pkg::S_ICMP: begin
            mem_we = 1'b1;
            if (new_first) begin
               // stored entry moves one slot back, hole moves forward
               mem_wdata = rd_data_ff;
               hole_in   = IW'(hole_ff - 1'b1);
            end else begin
               count_in = CW'(count_ff + 1'b1);
               rsp_in.status    = spjq_pkg::STAT_INSERTED;
               rsp_in.occupancy = spjq_pkg::OCC_W'(count_in);
            end
         end
         spjq_pkg::S_RM_RD: begin
            rd_addr = head_ff;
         end
         spjq_pkg::S_RM_DONE: begin
            head_in  = phys(head_ff, IW'(1));
            count_in = CW'(count_ff - 1'b1);
            rsp_in.status        = spjq_pkg::STAT_REMOVED;
            rsp_in.out_job_tag   = rd_data_ff.tag;
            rsp_in.out_priority  = rd_data_ff.prio;
            rsp_in.out_order_tag = rd_data_ff.order;
            rsp_in.occupancy     = spjq_pkg::OCC_W'(count_in);
         end
         spjq_pkg::S_RSP: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spjq_pkg::S_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff <= hole_in;
      new_ff  <= new_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

[hdl/spjq_checker.sv]
// port-level checks for the sorted priority job queue, bound to the top level
module spjq_checker #(
   parameter int CAPACITY = 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input spjq_pkg::rsp_payload_type rsp_payload
);

   // a waiting result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result waits");

   // only a remove carries entry fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != spjq_pkg::STAT_REMOVED) |->
         (rsp_payload.out_job_tag == '0) && (rsp_payload.out_priority == '0) &&
         (rsp_payload.out_order_tag == '0))
      else $error("non-remove item carries entry fields");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == spjq_pkg::STAT_EMPTY) |->
         (rsp_payload.occupancy == '0))
      else $error("empty status with nonzero occupancy");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == spjq_pkg::STAT_FULL) |->
         (rsp_payload.occupancy == spjq_pkg::OCC_W'(CAPACITY)))
      else $error("full status below capacity");

endmodule

bind sorted_priority_job_queue_unit spjq_checker #(.CAPACITY(CAPACITY)) u_spjq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
